// ----- hdl/adc_voltmeter_lcd_nibble_sequence_defines.svh -----
// ---------------------------------------------------------------------------
// adc_voltmeter_lcd_nibble_sequence_defines
// Assertion macros used by the checker of the LCD voltmeter sequencer.
// ---------------------------------------------------------------------------
`ifndef ADC_VOLTMETER_LCD_NIBBLE_SEQUENCE_DEFINES_SVH
`define ADC_VOLTMETER_LCD_NIBBLE_SEQUENCE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ADCV_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("adcv assertion failed");

// Next-cycle implication, checked outside reset
`define ADCV_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("adcv assertion failed");

`endif

// ----- hdl/adcv_pkg.sv -----
// ---------------------------------------------------------------------------
// adcv_pkg
// Types, constants and the transfer table of the LCD voltmeter sequencer.
// ---------------------------------------------------------------------------
package adcv_pkg;

  localparam int SAMPLE_W = 10;
  localparam int HUND_W   = 9;   // 0..499
  localparam int REM_W    = 7;   // 0..99
  localparam int DIGIT_W  = 4;
  localparam int NIB_W    = 4;
  localparam int BEFORE_W = 18;
  localparam int AFTER_W  = 13;

  localparam int RUN_LEN   = 19;
  localparam int STEP_W    = 5;
  localparam int RAW_STEPS = 3;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  // Scale: hundredths = (sample * 500) >> 10
  localparam int SCALE_MUL   = 500;
  localparam int SCALE_SHIFT = 10;
  // Divide by ten for values below 100: (x * 205) >> 11
  localparam int DIV10_MUL   = 205;
  localparam int DIV10_SHIFT = 11;

  localparam logic [NIB_W-1:0] RAW_NIB_INIT = 4'h3;
  localparam logic [NIB_W-1:0] RAW_NIB_MODE = 4'h2;

  localparam logic [7:0] CMD_FUNC_SET = 8'h28;
  localparam logic [7:0] CMD_DISP_ON  = 8'h0C;
  localparam logic [7:0] CMD_CLEAR    = 8'h01;
  localparam logic [7:0] CMD_ENTRY    = 8'h06;
  localparam logic [7:0] ASCII_ZERO   = 8'h30;
  localparam logic [7:0] ASCII_DOT    = 8'h2E;

  localparam logic [BEFORE_W-1:0] WAIT_POWER_US = 18'd200000;
  localparam logic [AFTER_W-1:0]  WAIT_SHORT_US = 13'd250;
  localparam logic [AFTER_W-1:0]  WAIT_CLEAR_US = 13'd5250;

  // Byte slots after the raw init nibbles
  localparam logic [3:0] SLOT_FUNC_SET = 4'd0;
  localparam logic [3:0] SLOT_DISP_ON  = 4'd1;
  localparam logic [3:0] SLOT_CLEAR    = 4'd2;
  localparam logic [3:0] SLOT_ENTRY    = 4'd3;
  localparam logic [3:0] SLOT_UNITS    = 4'd4;
  localparam logic [3:0] SLOT_DOT      = 4'd5;
  localparam logic [3:0] SLOT_TENTHS   = 4'd6;
  localparam logic [3:0] SLOT_HUNDS    = 4'd7;

  typedef struct packed {
    logic [DIGIT_W-1:0] units;
    logic [DIGIT_W-1:0] tenths;
    logic [DIGIT_W-1:0] hunds;
  } digits_t;

  // Push side of the queue between front and back
  typedef struct packed {
    logic    valid;
    digits_t digits;
  } q_push_t;

  typedef struct packed {
    logic [NIB_W-1:0]    nibble;
    logic                rs;
    logic [BEFORE_W-1:0] before_us;
    logic [AFTER_W-1:0]  after_us;
    logic                last;
  } xfer_t;

  // One transfer of the run, by step number
  function automatic xfer_t xfer_at(input logic [STEP_W-1:0] step, input digits_t dg);
    xfer_t              x;
    logic [STEP_W-1:0]  rel;
    logic [3:0]         slot;
    logic [7:0]         chr;
    x    = '0;
    rel  = step - STEP_W'(RAW_STEPS);
    slot = rel[4:1];
    chr  = 8'h00;
    if (step < STEP_W'(RAW_STEPS)) begin
      x.nibble    = (step == STEP_W'(RAW_STEPS - 1)) ? RAW_NIB_MODE : RAW_NIB_INIT;
      x.before_us = (step == '0) ? WAIT_POWER_US : '0;
      x.after_us  = WAIT_SHORT_US;
    end else begin
      case (slot)
        SLOT_FUNC_SET: chr = CMD_FUNC_SET;
        SLOT_DISP_ON:  chr = CMD_DISP_ON;
        SLOT_CLEAR:    chr = CMD_CLEAR;
        SLOT_ENTRY:    chr = CMD_ENTRY;
        SLOT_UNITS:    chr = ASCII_ZERO | {4'h0, dg.units};
        SLOT_DOT:      chr = ASCII_DOT;
        SLOT_TENTHS:   chr = ASCII_ZERO | {4'h0, dg.tenths};
        SLOT_HUNDS:    chr = ASCII_ZERO | {4'h0, dg.hunds};
        default:       chr = 8'h00;
      endcase
      x.rs     = (slot >= SLOT_UNITS);
      x.nibble = rel[0] ? chr[3:0] : chr[7:4];
      if (rel[0]) begin
        x.after_us = (slot == SLOT_CLEAR) ? WAIT_CLEAR_US : WAIT_SHORT_US;
      end
    end
    x.last = (step == STEP_W'(RUN_LEN - 1));
    return x;
  endfunction

endpackage

// ----- hdl/adcv_front.sv -----
// ---------------------------------------------------------------------------
// adcv_front
// Accepts samples, scales them to hundredths of a volt and splits digits.
// ---------------------------------------------------------------------------
module adcv_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [adcv_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                          q_ready,
  output adcv_pkg::q_push_t             q_push
);

  localparam int PROD_W = adcv_pkg::SAMPLE_W + 9;
  localparam int DIV_W  = adcv_pkg::REM_W + 8;

  logic                        s1_valid_r, s1_valid_nxt;
  logic [adcv_pkg::HUND_W-1:0] s1_hund_r;
  logic                        s2_valid_r, s2_valid_nxt;
  logic [adcv_pkg::DIGIT_W-1:0] s2_units_r;
  logic [adcv_pkg::REM_W-1:0]  s2_rem_r;

  logic [PROD_W-1:0]            prod;
  logic                         s1_ready, s2_ready;
  logic [adcv_pkg::DIGIT_W-1:0] units;
  logic [adcv_pkg::HUND_W-1:0]  rem_full;
  logic [DIV_W-1:0]             div_prod;
  logic [adcv_pkg::DIGIT_W-1:0] tens;
  logic [adcv_pkg::REM_W-1:0]   ones_full;

  // Stage handshakes
  assign s2_ready = !s2_valid_r || q_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage 1: hundredths = (sample * 500) >> 10
  assign prod = PROD_W'(in_sample) * PROD_W'(adcv_pkg::SCALE_MUL);

  // Stage 2: units digit by range compare, remainder below 100
  always_comb begin
    if (s1_hund_r >= 9'd400)      units = 4'd4;
    else if (s1_hund_r >= 9'd300) units = 4'd3;
    else if (s1_hund_r >= 9'd200) units = 4'd2;
    else if (s1_hund_r >= 9'd100) units = 4'd1;
    else                          units = 4'd0;
    rem_full = s1_hund_r - (adcv_pkg::HUND_W'(units) * 9'd100);
  end

  // Queue push: tenths by reciprocal multiply, hundredths digit as remainder
  assign div_prod  = DIV_W'(s2_rem_r) * DIV_W'(adcv_pkg::DIV10_MUL);
  assign tens      = div_prod[adcv_pkg::DIV10_SHIFT +: adcv_pkg::DIGIT_W];
  assign ones_full = s2_rem_r - {tens, 3'b000} - {2'b00, tens, 1'b0};

  assign q_push.valid         = s2_valid_r;
  assign q_push.digits.units  = s2_units_r;
  assign q_push.digits.tenths = tens;
  assign q_push.digits.hunds  = ones_full[adcv_pkg::DIGIT_W-1:0];

  // Valid bits
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s2_valid_nxt = s2_valid_r;
    if (s1_ready) s1_valid_nxt = in_valid;
    if (s2_ready) s2_valid_nxt = s1_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_hund_r <= prod[adcv_pkg::SCALE_SHIFT +: adcv_pkg::HUND_W];
    end
    if (s2_ready && s1_valid_r) begin
      s2_units_r <= units;
      s2_rem_r   <= rem_full[adcv_pkg::REM_W-1:0];
    end
  end

endmodule

// ----- hdl/adcv_queue.sv -----
// ---------------------------------------------------------------------------
// adcv_queue
// Two-entry digit queue decoupling the front stages from the sequencer.
// ---------------------------------------------------------------------------
module adcv_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  adcv_pkg::q_push_t push,
  output logic              push_ready,
  input  logic              pop,
  output logic              head_valid,
  output adcv_pkg::digits_t head
);

  adcv_pkg::digits_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push.digits;
  end

endmodule

// ----- hdl/adcv_back.sv -----
// ---------------------------------------------------------------------------
// adcv_back
// Steps through the 19 nibble transfers of a run into an output register.
// ---------------------------------------------------------------------------
module adcv_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  adcv_pkg::digits_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output adcv_pkg::xfer_t   out_xfer
);

  logic [adcv_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        out_valid_r, out_valid_nxt;
  adcv_pkg::xfer_t             out_xfer_r;
  adcv_pkg::xfer_t             cur;
  logic                        load, fire;

  assign load = !out_valid_r || out_ready;
  assign fire = load && head_valid;
  assign cur  = adcv_pkg::xfer_at(step_r, head);
  assign pop  = fire && cur.last;

  assign out_valid = out_valid_r;
  assign out_xfer  = out_xfer_r;

  // Step counter and output valid
  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = head_valid;
    if (fire) step_nxt = cur.last ? '0 : step_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (fire) out_xfer_r <= cur;
  end

endmodule

// ----- hdl/adc_voltmeter_lcd_nibble_sequence.sv -----
// ---------------------------------------------------------------------------
// adc_voltmeter_lcd_nibble_sequence
// Voltmeter front end that turns each ADC sample into a 4-bit LCD run.
// ---------------------------------------------------------------------------
//  channel | direction | fields
//  in_     | slave     | tdata: adc_sample
//  out_    | master    | tdata: lcd_nibble, wait_before_us, wait_after_us;
//          |           | tuser: register_select; tlast: last_transfer
//
// Each sample yields 19 transfers, one per cycle from the back sequencer while
// out_tready is high; the sequencer step counter walks through them.
// The first transfer passes front stage 2, the queue and the output register, in
// that order, after the stage 1 capture at the sample's accepting edge.
// Samples keep being accepted while a run is emitted until the two-entry
// queue and front stages are full.
// rst_n is synchronous; it clears all valid bits, pointers and the step count.
// ---------------------------------------------------------------------------
module adc_voltmeter_lcd_nibble_sequence (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [adcv_pkg::IN_TDATA_W-1:0]  in_tdata,   // [9:0] adc_sample
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [adcv_pkg::OUT_TDATA_W-1:0] out_tdata,  // [3:0] lcd_nibble,
                                                       // [21:4] wait_before_us,
                                                       // [34:22] wait_after_us
  output logic                             out_tuser,  // [0] register_select
  output logic                             out_tlast
);

  adcv_pkg::q_push_t q_push;
  logic              q_ready;
  logic              head_valid;
  adcv_pkg::digits_t head;
  logic              pop;
  adcv_pkg::xfer_t   xfer;

  adcv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample (in_tdata[adcv_pkg::SAMPLE_W-1:0]),
    .q_ready   (q_ready),
    .q_push    (q_push)
  );

  adcv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  adcv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_xfer   (xfer)
  );

  // Output packing
  assign out_tdata = {5'b00000, xfer.after_us, xfer.before_us, xfer.nibble};
  assign out_tuser = xfer.rs;
  assign out_tlast = xfer.last;

endmodule

// ----- hdl/adcv_checker.sv -----
// ---------------------------------------------------------------------------
// adcv_checker
// Port-level checks on the nibble run shape, bound to the top level.
// ---------------------------------------------------------------------------
`include "adc_voltmeter_lcd_nibble_sequence_defines.svh"

module adcv_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [adcv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [adcv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tuser,
  input logic                             out_tlast
);

  logic [adcv_pkg::STEP_W-1:0] cnt_r, cnt_nxt;
  logic                        out_fire;
  logic                        in_stall, out_stall;
  logic [adcv_pkg::OUT_TDATA_W+1:0] out_word;
  logic                        last_pos, data_pos, first_ok;

  assign out_fire  = out_tvalid && out_tready;
  assign in_stall  = in_tvalid && !in_tready;
  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tdata, out_tuser, out_tlast};

  // Position of the current item within its run
  always_comb begin
    cnt_nxt = cnt_r;
    if (out_fire) cnt_nxt = out_tlast ? '0 : cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else        cnt_r <= cnt_nxt;
  end

  // Run landmarks; characters start at transfer 11
  assign last_pos = (cnt_r == adcv_pkg::STEP_W'(adcv_pkg::RUN_LEN - 1));
  assign data_pos = (cnt_r >= 5'd11);
  assign first_ok = (out_tdata[3:0] == adcv_pkg::RAW_NIB_INIT) &&
                    (out_tdata[21:4] == adcv_pkg::WAIT_POWER_US);

  // Offered sample holds while stalled
  `ADCV_ASSERT_NXT(a_in_hold, in_stall, in_tvalid && $stable(in_tdata))

  // Stalled item holds
  `ADCV_ASSERT_NXT(a_out_hold, out_stall, out_tvalid && $stable(out_word))

  // Run length is fixed
  `ADCV_ASSERT_IMP(a_last_pos, out_tvalid, out_tlast == last_pos)

  // Run opens with the power-up wait on an init nibble
  `ADCV_ASSERT_IMP(a_first_xfer, out_tvalid && (cnt_r == '0), first_ok)

  // Only the character transfers select the data register
  `ADCV_ASSERT_IMP(a_rs_pos, out_tvalid, out_tuser == data_pos)

endmodule

bind adc_voltmeter_lcd_nibble_sequence adcv_checker u_adcv_checker (.*);
